### src/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types and constants of the range sum counter.
// ----------------------------------------------------------------------------
package rsc_pkg;

	localparam int MAX_ELEMENTS = 1023;
	localparam int STORE_DEPTH  = MAX_ELEMENTS + 1;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W        = $clog2(STORE_DEPTH + 1);

	localparam int VALUE_W      = 32;
	localparam int SUM_W        = VALUE_W + $clog2(STORE_DEPTH);
	localparam int DIFF_W       = SUM_W + 1;
	localparam int HITS_W       = 11;
	localparam int TOTAL_W      = 20;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

	// configuration registers, byte address 4*index
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_RANGE_LOW  = 1'b0;
	localparam logic REG_RANGE_HIGH = 1'b1;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      first;
	} in_item_t;

	typedef struct packed {
		logic [HITS_W-1:0]  ending_here;
		logic [TOTAL_W-1:0] running_total;
		logic               store_full;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic drop;
		logic scan;
		logic commit;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

### src/rsc_ram.sv
// ----------------------------------------------------------------------------
// rsc_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module rsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### src/rsc_datapath.sv
// ----------------------------------------------------------------------------
// rsc_datapath
// Prefix sum, bound window, prefix store scan, totals and output register.
// ----------------------------------------------------------------------------
module rsc_datapath import rsc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dp_cmd_t                   cmd,
	output dp_status_t                status,
	input  in_item_t                  in_data,
	input  logic signed [VALUE_W-1:0] range_low,
	input  logic signed [VALUE_W-1:0] range_high,
	output logic                      out_valid,
	input  logic                      out_ready,
	output out_item_t                 out_data
);

	logic signed [SUM_W-1:0]  sum_q;
	logic signed [SUM_W-1:0]  s_q;
	logic signed [SUM_W-1:0]  sum_base;
	logic [CNT_W-1:0]         count_q;
	logic [TOTAL_W-1:0]       total_q;
	logic [TOTAL_W:0]         total_add;
	logic [TOTAL_W-1:0]       total_next;
	logic signed [DIFF_W-1:0] lo_q;
	logic signed [DIFF_W-1:0] hi_q;
	logic [CNT_W-1:0]         idx_q;
	logic [CNT_W-1:0]         hits_q;
	logic                     rd_vld_s1;
	logic                     zero_s1;
	logic [SUM_W-1:0]         rd_data;
	logic signed [DIFF_W-1:0] prefix;
	logic                     hit;
	out_item_t                res_q;
	logic                     out_valid_q;
	out_item_t                out_q;

	rsc_ram #(
		.WIDTH(SUM_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (cmd.commit),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_data(s_q),
		.rd_addr(idx_q[ADDR_W-1:0]),
		.rd_data(rd_data)
	);

	// entry 0 is the zero prefix and is never written
	assign prefix   = zero_s1 ? '0 : DIFF_W'(signed'(rd_data));
	assign hit      = (prefix >= lo_q) && (prefix <= hi_q);
	assign sum_base = in_data.first ? '0 : sum_q;

	assign total_add  = {1'b0, total_q} + (TOTAL_W + 1)'(hits_q);
	assign total_next = (total_add > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_add[TOTAL_W-1:0];

	assign status.full      = count_q >= CNT_W'(STORE_DEPTH);
	assign status.scan_last = idx_q == (count_q - CNT_W'(1));
	assign status.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= CNT_W'(1);
			total_q     <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
			if (cmd.load && in_data.first) begin
				sum_q   <= '0;
				count_q <= CNT_W'(1);
				total_q <= '0;
			end else if (cmd.commit) begin
				sum_q   <= s_q;
				count_q <= count_q + CNT_W'(1);
				total_q <= total_next;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q <= sum_base + SUM_W'(in_data.value);
		end
		if (cmd.prep) begin
			lo_q   <= DIFF_W'(s_q) - DIFF_W'(range_high);
			hi_q   <= DIFF_W'(s_q) - DIFF_W'(range_low);
			idx_q  <= '0;
			hits_q <= '0;
		end else begin
			if (cmd.scan) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			if (rd_vld_s1 && hit) begin
				hits_q <= hits_q + CNT_W'(1);
			end
		end
		zero_s1 <= idx_q == '0;
		if (cmd.drop) begin
			res_q.ending_here   <= '0;
			res_q.running_total <= total_q;
			res_q.store_full    <= 1'b1;
		end else if (cmd.commit) begin
			res_q.ending_here   <= HITS_W'(hits_q);
			res_q.running_total <= total_next;
			res_q.store_full    <= 1'b0;
		end
		if (cmd.emit) begin
			out_q <= res_q;
		end
	end

endmodule

### src/rsc_ctrl.sv
// ----------------------------------------------------------------------------
// rsc_ctrl
// Sequencer: accept, set up the window (or drop when the store is full), scan the store, commit, hand off.
// ----------------------------------------------------------------------------
module rsc_ctrl import rsc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = state_q == ST_IDLE;

	always_comb begin
		cmd        = '0;
		cmd.load   = (state_q == ST_IDLE) && in_valid;
		cmd.prep   = (state_q == ST_PREP) && !status.full;
		cmd.drop   = (state_q == ST_PREP) && status.full;
		cmd.scan   = state_q == ST_SCAN;
		cmd.commit = state_q == ST_COMMIT;
		cmd.emit   = (state_q == ST_EMIT) && status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_PREP;
				end
				ST_PREP: begin
					state_q <= status.full ? ST_EMIT : ST_SCAN;
				end
				ST_SCAN: begin
					if (status.scan_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (status.out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### src/range_sum_counter_top.sv
// ----------------------------------------------------------------------------
// range_sum_counter_top
// Counts ranges of a signed stream whose sums fall inside a programmed window.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one element per
//   transfer; in_data.first starts a new sequence before that element.
//   Output channel (out_valid/out_ready/out_data) returns one result per
//   element: ranges ending here, running total, and a dropped flag.
//   The APB port holds range_low (0x0) and range_high (0x4); write them
//   only while the block is idle.
// Operation:
//   Per element: set up the window, scan the N stored prefixes (1 to
//   1023) with one read and compare per stored prefix, drain, commit,
//   then hand the result to the output register; only then is the next
//   element taken. A dropped element (store full) skips to the hand-off.
// Reset:
//   arst_n clears the sequence to the single zero prefix, zeroes the
//   totals and both bounds. The prefix RAM needs no clearing pass.
// Stall:
//   A finished result sits in the output register; the next element is
//   already taken in meanwhile and its result waits until that register
//   is free.
// ----------------------------------------------------------------------------
module range_sum_counter_top import rsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// element stream
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	// result stream
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data
);

	logic signed [VALUE_W-1:0] range_low_q;
	logic signed [VALUE_W-1:0] range_high_q;
	logic                      cfg_wr;
	dp_cmd_t                   cmd;
	dp_status_t                status;

	// zero-wait APB: a write lands on the access cycle
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q  <= '0;
			range_high_q <= '0;
		end else if (cfg_wr) begin
			// decode by word index, ignore the byte offset
			unique case (paddr[2])
				REG_RANGE_LOW:  range_low_q  <= pwdata;
				REG_RANGE_HIGH: range_high_q <= pwdata;
				default:        range_low_q  <= range_low_q;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_RANGE_LOW:  prdata = range_low_q;
			REG_RANGE_HIGH: prdata = range_high_q;
			default:        prdata = '0;
		endcase
	end

	// sequencer: one element at a time through the prefix scan
	rsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.status  (status),
		.cmd     (cmd)
	);

	// prefix store, window compare and output register
	rsc_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.in_data   (in_data),
		.range_low (range_low_q),
		.range_high(range_high_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

### src/rsc_checker.sv
// ----------------------------------------------------------------------------
// rsc_checker
// Port-level checks of the range sum counter, bound to the top level.
// ----------------------------------------------------------------------------
module rsc_checker import rsc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	// one element at a time: ready drops right after a transfer
	a_in_single: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("element taken while busy");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// a dropped element counts nothing
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.store_full |-> out_data.ending_here == '0)
		else $error("dropped element reported hits");

	// no more hits than store entries
	a_hits_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.ending_here <= HITS_W'(STORE_DEPTH))
		else $error("hit count above store depth");

	// the total includes this element's hits
	a_total_ge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.store_full |->
			out_data.running_total >= TOTAL_W'(out_data.ending_here))
		else $error("running total below hit count");

endmodule

bind range_sum_counter_top rsc_checker u_rsc_checker (.*);

### dv/tb_range_sum_counter_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_range_sum_counter_top
// Self-checking bench for the range sum counter.
// Elements stream in over valid/ready and the bench predicts each result from
// its own copy of the prefix store and the programmed window. Results are
// compared field by field in order. Directed cases open the run. Random
// sequences under random windows follow, with both sides idling now and
// then.
// ----------------------------------------------------------------------------
module tb_range_sum_counter_top;
	import rsc_pkg::*;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam int CYCLE_LIMIT  = 3_000_000;
	localparam int RANDOM_ITEMS = 556;
	localparam int MAX_RUN      = 40;

	// Predicts the count of in-window ranges per element and holds the
	// results still owed by the block.
	class range_tally_board;
		longint    prefix_sums[STORE_DEPTH];
		int        fill;
		longint    run_sum;
		int        total;
		longint    low_bound;
		longint    high_bound;
		out_item_t tally_q[$];
		int        fails;

		function new();
			low_bound  = 0;
			high_bound = 0;
			fails      = 0;
			restart();
		endfunction

		function void restart();
			prefix_sums[0] = 0;
			fill           = 1;
			run_sum        = 0;
			total          = 0;
		endfunction

		function void set_bounds(logic signed [VALUE_W-1:0] lo,
				logic signed [VALUE_W-1:0] hi);
			low_bound  = longint'(lo);
			high_bound = longint'(hi);
		endfunction

		function int pending();
			return tally_q.size();
		endfunction

		function void note_element(in_item_t item);
			out_item_t res;
			longint    s;
			longint    d;
			int        hits;
			if (item.first) begin
				restart();
			end
			if (fill >= STORE_DEPTH) begin
				// store full: drop the element, report the held total
				res.ending_here   = '0;
				res.running_total = TOTAL_W'(total);
				res.store_full    = 1'b1;
			end else begin
				s    = run_sum + longint'(item.value);
				hits = 0;
				for (int i = 0; i < fill; i++) begin
					d = s - prefix_sums[i];
					if (d >= low_bound && d <= high_bound) begin
						hits++;
					end
				end
				prefix_sums[fill] = s;
				fill++;
				run_sum = s;
				if (hits > int'(TOTAL_MAX) - total) begin
					total = int'(TOTAL_MAX);
				end else begin
					total += hits;
				end
				res.ending_here   = HITS_W'(hits);
				res.running_total = TOTAL_W'(total);
				res.store_full    = 1'b0;
			end
			tally_q.push_back(res);
		endfunction

		task report_mismatch(string msg);
			if (fails < 200) begin
				$display("MISMATCH at %0t: %s", $realtime, msg);
			end
			fails++;
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			if (tally_q.size() == 0) begin
				report_mismatch($sformatf("result %0d/%0d/%0d with no element outstanding",
					got.ending_here, got.running_total, got.store_full));
			end else begin
				want = tally_q.pop_front();
				if (got.ending_here !== want.ending_here) begin
					report_mismatch($sformatf("ending_here got %0d expected %0d",
						got.ending_here, want.ending_here));
				end
				if (got.running_total !== want.running_total) begin
					report_mismatch($sformatf("running_total got %0d expected %0d",
						got.running_total, want.running_total));
				end
				if (got.store_full !== want.store_full) begin
					report_mismatch($sformatf("store_full got %0b expected %0b",
						got.store_full, want.store_full));
				end
			end
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid;
	logic               in_ready;
	in_item_t           in_data;
	logic               out_valid;
	logic               out_ready;
	out_item_t          out_data;

	range_tally_board board;
	bit               calm;      // high while neither side may idle
	int               cycle_count;

	range_sum_counter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	always #5 clk = ~clk;

	// Bound the run; a hang anywhere ends here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Stall the result side about 7 percent of the time, never while calm.
	initial begin
		forever begin
			@(negedge clk);
			out_ready <= calm || ($urandom_range(99) >= 7);
		end
	end

	// Check every result transfer against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			board.check_result(out_data);
		end
	end

	// One APB access: setup phase, access phase, then release the bus.
	task automatic apb_access(input logic wr, input logic idx,
			input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_bounds(input logic signed [VALUE_W-1:0] lo,
			input logic signed [VALUE_W-1:0] hi);
		logic [PDATA_W-1:0] rd;
		apb_access(1'b0, REG_RANGE_LOW, '0, rd);
		if (rd !== lo) begin
			board.report_mismatch($sformatf("range_low reads %0d expected %0d",
				$signed(rd), lo));
		end
		apb_access(1'b0, REG_RANGE_HIGH, '0, rd);
		if (rd !== hi) begin
			board.report_mismatch($sformatf("range_high reads %0d expected %0d",
				$signed(rd), hi));
		end
	endtask

	task automatic program_bounds(input logic signed [VALUE_W-1:0] lo,
			input logic signed [VALUE_W-1:0] hi);
		logic [PDATA_W-1:0] rd;
		apb_access(1'b1, REG_RANGE_LOW, lo, rd);
		apb_access(1'b1, REG_RANGE_HIGH, hi, rd);
		board.set_bounds(lo, hi);
		check_bounds(lo, hi);
	endtask

	// Present one element and hold it until the transfer; maybe idle first.
	task automatic send_element(input logic signed [VALUE_W-1:0] v, input logic f);
		in_item_t item;
		item.value = v;
		item.first = f;
		@(negedge clk);
		while (!calm && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		board.note_element(item);
	endtask

	// Drop valid and hold until every owed result has come back.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (board.pending() != 0) begin
			@(negedge clk);
		end
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(99);
		if (r < 60) begin
			return int'($urandom_range(40)) - 20;
		end else if (r < 80) begin
			return int'($urandom_range(10000)) - 5000;
		end else if (r < 95) begin
			return $urandom;
		end
		case ($urandom_range(3))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return 0;
			default: return -1;
		endcase
	endfunction

	task automatic pick_window(output logic signed [VALUE_W-1:0] lo,
			output logic signed [VALUE_W-1:0] hi);
		case ($urandom_range(5))
			0: begin
				lo = -int'($urandom_range(30));
				hi = int'($urandom_range(30));
			end
			1: begin
				lo = $urandom;
				hi = $urandom;
			end
			2: begin
				lo = VAL_MIN;
				hi = int'($urandom_range(100)) - 50;
			end
			3: begin
				lo = int'($urandom_range(100)) - 50;
				hi = VAL_MAX;
			end
			4: begin
				lo = int'($urandom_range(20));
				hi = lo + int'($urandom_range(40));
			end
			default: begin
				lo = int'($urandom_range(10)) - 5;
				hi = lo;
			end
		endcase
	endtask

	initial begin
		logic signed [VALUE_W-1:0] lo;
		logic signed [VALUE_W-1:0] hi;
		int run_len;
		logic f;

		board       = new();
		calm        = 1'b0;
		cycle_count = 0;
		clk         = 1'b0;
		arst_n      = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		in_valid    = 1'b0;
		in_data     = '0;
		out_ready   = 1'b0;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Bounds come out of reset as zero; run a few elements on them
		// without a sequence start.
		check_bounds(0, 0);
		send_element(0, 1'b0);
		send_element(0, 1'b0);
		send_element(5, 1'b0);
		send_element(-5, 1'b0);
		wait_drained();

		// Widest window; prefix sums run far past 32 bits both ways.
		program_bounds(VAL_MIN, VAL_MAX);
		send_element(VAL_MAX, 1'b1);
		send_element(VAL_MAX, 1'b0);
		send_element(VAL_MIN, 1'b0);
		send_element(VAL_MIN, 1'b0);
		send_element(VAL_MIN, 1'b0);
		wait_drained();

		// Empty window: low above high, nothing may count.
		program_bounds(7, -7);
		send_element(3, 1'b1);
		send_element(-3, 1'b0);
		send_element(0, 1'b0);
		wait_drained();

		// Single-point windows at both extremes.
		program_bounds(VAL_MIN, VAL_MIN);
		send_element(VAL_MIN, 1'b1);
		send_element(0, 1'b0);
		send_element(VAL_MIN, 1'b0);
		wait_drained();
		program_bounds(VAL_MAX, VAL_MAX);
		send_element(VAL_MAX, 1'b1);
		send_element(VAL_MAX, 1'b0);
		send_element(0, 1'b0);
		wait_drained();

		// Small window with a sequence restart in the middle.
		program_bounds(-3, 4);
		send_element(2, 1'b1);
		send_element(-1, 1'b0);
		send_element(4, 1'b0);
		send_element(-6, 1'b1);
		send_element(3, 1'b0);
		send_element(1, 1'b0);
		wait_drained();

		// Random sequences under random windows; a new window every phase.
		run_len = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 83 == 0) begin
				wait_drained();
				pick_window(lo, hi);
				program_bounds(lo, hi);
			end
			calm = (n >= 200 && n < 330);
			f = (run_len >= MAX_RUN) || ($urandom_range(29) == 0);
			run_len = f ? 1 : run_len + 1;
			send_element(pick_value(), f);
		end
		calm = 1'b0;
		wait_drained();

		// Give a stray late result time to show up.
		repeat (1100) @(posedge clk);
		if (board.fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
